### hdl/fta_pkg.sv
package fta_pkg;

  localparam int unsigned RpmW   = 21;
  localparam int unsigned CountW = 8;
  localparam int unsigned ExpW   = 3;
  localparam int unsigned RegW   = 8;

  localparam logic [RpmW-1:0]   RpmNumerator  = 21'd1350000;
  localparam logic [CountW-1:0] CountOverflow = 8'hFF;
  localparam logic [CountW-1:0] CountZero     = 8'h00;
  localparam logic [ExpW-1:0]   Fan2Exp       = 3'd1;

  localparam logic [1:0] FanIdx0   = 2'd0;
  localparam logic [1:0] FanIdx1   = 2'd1;
  localparam logic [1:0] FanIdx2   = 2'd2;
  localparam logic [1:0] FanIdxBad = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadIndex = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;
  localparam logic [1:0] StZero     = 2'd3;

  // Classified word handed from the front end to the divider.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [ExpW-1:0]   exponent;
    logic [1:0]        status;
    logic              write_divisor;
    logic [RegW-1:0]   new_divisor_reg;
  } fta_item_t;

  // One divider stage: word plus partial remainder and quotient.
  typedef struct packed {
    fta_item_t         item;
    logic [CountW-1:0] rem;
    logic [RpmW-1:0]   quo;
  } fta_stage_t;

endpackage

### hdl/fta_front.sv
module fta_front (
  input  logic [1:0]          fan_index_i,
  input  logic [7:0]          divisor_reg_i,
  input  logic [7:0]          tach_count_i,
  output fta_pkg::fta_item_t  item_o
);
  import fta_pkg::*;

  logic [ExpW-1:0] exp0;
  logic [ExpW-1:0] exp1;
  logic [ExpW-1:0] exp0_next;
  logic [ExpW-1:0] exp1_next;

  assign exp0 = divisor_reg_i[2:0];
  assign exp1 = divisor_reg_i[5:3];

  always_comb begin
    exp0_next = exp0;
    exp1_next = exp1;
    item_o.count           = tach_count_i;
    item_o.status          = StOk;
    item_o.write_divisor   = 1'b0;
    item_o.new_divisor_reg = divisor_reg_i;
    unique case (fan_index_i)
      FanIdx0: item_o.exponent = exp0;
      FanIdx1: item_o.exponent = exp1;
      default: item_o.exponent = Fan2Exp;
    endcase

    priority if (fan_index_i == FanIdxBad) begin
      item_o.status = StBadIndex;
    end else if (tach_count_i == CountOverflow) begin
      item_o.status = StOverflow;
      if (fan_index_i != FanIdx2) begin
        // advance the exponent, 7 wraps to 0
        if (fan_index_i == FanIdx0) begin
          exp0_next = exp0 + 3'd1;
        end else begin
          exp1_next = exp1 + 3'd1;
        end
        item_o.write_divisor   = 1'b1;
        item_o.new_divisor_reg = {divisor_reg_i[7:6], exp1_next, exp0_next};
      end
    end else if (tach_count_i == CountZero) begin
      item_o.status = StZero;
    end else begin
      item_o.status = StOk;
    end
  end

endmodule

### hdl/fta_queue.sv
module fta_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  fta_pkg::fta_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               head_valid_o,
  output fta_pkg::fta_item_t head_item_o
);
  import fta_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fta_item_t           slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/fta_back.sv
module fta_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  fta_pkg::fta_item_t head_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [20:0]        rpm_o,
  output logic [1:0]         status_o,
  output logic               write_divisor_o,
  output logic [7:0]         new_divisor_reg_o
);
  import fta_pkg::*;

  localparam int unsigned QBits = RpmW;

  fta_stage_t      stage_q [QBits+1];
  fta_stage_t      stage_d [QBits+1];
  logic            valid_q [QBits+1];
  logic            advance;
  logic            out_valid_q;
  logic [RpmW-1:0] rpm_q;
  fta_item_t       out_item_q;

  // the whole pipe moves as one whenever the output register frees up
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance;

  always_comb begin
    stage_d[0].item = head_item_i;
    stage_d[0].rem  = '0;
    stage_d[0].quo  = '0;
  end

  // restoring division of the fixed numerator by the count, one quotient bit a stage
  for (genvar gi = 0; gi < QBits; gi++) begin : g_div
    logic [CountW:0] rem_shift;
    logic [CountW:0] trial;
    logic            take;

    assign rem_shift = {stage_q[gi].rem, RpmNumerator[QBits-1-gi]};
    assign trial     = rem_shift - {1'b0, stage_q[gi].item.count};
    assign take      = (rem_shift >= {1'b0, stage_q[gi].item.count});

    always_comb begin
      stage_d[gi+1].item = stage_q[gi].item;
      stage_d[gi+1].rem  = take ? trial[CountW-1:0] : rem_shift[CountW-1:0];
      stage_d[gi+1].quo  = {stage_q[gi].quo[QBits-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QBits; i++) begin
        valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= head_valid_i;
      for (int i = 1; i <= QBits; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      out_valid_q <= valid_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int i = 0; i <= QBits; i++) begin
        stage_q[i] <= stage_d[i];
      end
      out_item_q <= stage_q[QBits].item;
      // floor(N / (c << e)) equals floor(N / c) >> e
      rpm_q <= (stage_q[QBits].item.status == StOk) ?
               (stage_q[QBits].quo >> stage_q[QBits].item.exponent) : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rpm_o             = rpm_q;
  assign status_o          = out_item_q.status;
  assign write_divisor_o   = out_item_q.write_divisor;
  assign new_divisor_reg_o = out_item_q.new_divisor_reg;

endmodule

### hdl/fan_tach_rpm_autorange.sv
// Fan tach to RPM converter with automatic divisor ranging.
//
// Input channel (in_valid_i / in_stall_o): one word per fan read, carrying
// the fan index, the current divisor register byte and the raw tach count.
// A word is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): exactly one result word per
// input word, in order: rpm, status, and a divisor register byte with its
// write request when a fan 0 or fan 1 count overflowed.
//
// Throughput: one word per cycle while out_stall_i is low. A word passes
// from acceptance to out_valid_o through the queue slot, the 21-stage
// restoring divider (one quotient bit per stage) and the output register.
// The front end classifies each word and drops it into a small queue; the
// divider pipe advances whenever its output register is empty or taken.
// When the receiver stalls, the result holds steady, the divider freezes and
// the queue absorbs up to QueueDepth more words before in_stall_o rises.
// Reset empties the queue and the divider; no results are pending after it.
module fan_tach_rpm_autorange #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  fan_index_i,
  input  logic [7:0]  divisor_reg_i,
  input  logic [7:0]  tach_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] rpm_o,
  output logic [1:0]  status_o,
  output logic        write_divisor_o,
  output logic [7:0]  new_divisor_reg_o
);
  import fta_pkg::*;

  fta_item_t front_item;
  fta_item_t head_item;
  logic      queue_full;
  logic      head_valid;
  logic      pop;

  // classify: status, exponent, and the divisor write on overflow
  fta_front u_front (
    .fan_index_i  (fan_index_i),
    .divisor_reg_i(divisor_reg_i),
    .tach_count_i (tach_count_i),
    .item_o       (front_item)
  );

  // decouple the classifier from the divider pipe
  fta_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_item_o (head_item)
  );

  assign in_stall_o = queue_full;

  // divide, scale by the exponent, register the result
  fta_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_valid_i     (head_valid),
    .head_item_i      (head_item),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rpm_o            (rpm_o),
    .status_o         (status_o),
    .write_divisor_o  (write_divisor_o),
    .new_divisor_reg_o(new_divisor_reg_o)
  );

endmodule

### hdl/fta_checker.sv
module fta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [20:0] rpm_o,
  input logic [1:0]  status_o,
  input logic        write_divisor_o
);
  import fta_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_rpm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> (rpm_o == '0))
    else $error("rpm nonzero on a failed read");

  // smallest rpm for a good read is 1350000 / (254 << 7), still above zero
  a_rpm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StOk) |-> (rpm_o != '0))
    else $error("rpm zero on a good read");

  a_write_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_divisor_o |-> (status_o == StOverflow))
    else $error("divisor write without count overflow");

endmodule

bind fan_tach_rpm_autorange fta_checker u_fta_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .rpm_o          (rpm_o),
  .status_o       (status_o),
  .write_divisor_o(write_divisor_o)
);
